/* rtl/omni_drive_lease_arbiter_assert.svh */
// Assertion macros used by the arbiter's queue.
`ifndef OMNI_DRIVE_LEASE_ARBITER_ASSERT_SVH
`define OMNI_DRIVE_LEASE_ARBITER_ASSERT_SVH

// Flag a condition that must never be seen outside reset.
`define OLDA_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// Flag a broken non-overlapping implication.
`define OLDA_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/olda_pkg.sv */
package olda_pkg;

  localparam int SOURCES   = 4;
  localparam int DUTY_MAX  = 1023;
  localparam int K_SQRT3_2 = 56756;
  localparam int PCT_MAX   = 100;
  localparam logic [6:0] PCT_RESET = 7'd40;

  // Action codes
  localparam logic [1:0] ACT_REQUEST = 2'd0;
  localparam logic [1:0] ACT_STOP    = 2'd2;

  // Register indexes
  localparam logic REG_PERCENT = 1'b0;
  localparam logic REG_ENABLE  = 1'b1;

  // Datapath widths
  localparam int W_W  = 36;
  localparam int M_W  = 35;
  localparam int DH_W = 42;
  localparam int N_W  = 54;
  localparam int S_W  = 17;
  localparam int Q_W  = 11;

  typedef logic signed [15:0] vel_t;
  typedef logic [47:0] time_t;
  typedef logic signed [10:0] duty_t;

  typedef struct packed {
    vel_t rot_z;
    vel_t vel_y;
    vel_t vel_x;
  } slot_vel_t;

  typedef struct packed {
    slot_vel_t  vel;
    logic [2:0] winner;
  } entry_t;

  typedef enum logic {F_IDLE, F_EVAL} front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_KIN, B_SUM, B_PEAK, B_MUL, B_DIV, B_OUT
  } back_state_t;

endpackage

/* rtl/olda_if.sv */
interface olda_cmd_if import olda_pkg::*;;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [1:0]  source_id;
  vel_t        vel_x;
  vel_t        vel_y;
  vel_t        rot_z;
  logic [15:0] lease_ms;
  time_t       now_ms;

  modport source (output valid, action, source_id, vel_x, vel_y, rot_z, lease_ms, now_ms,
                  input ready);
  modport sink (input valid, action, source_id, vel_x, vel_y, rot_z, lease_ms, now_ms,
                output ready);
endinterface

interface olda_duty_if import olda_pkg::*;;
  logic       valid;
  logic       ready;
  duty_t      duty_a;
  duty_t      duty_b;
  duty_t      duty_c;
  logic [2:0] winner;
  logic       drive_active;

  modport source (output valid, duty_a, duty_b, duty_c, winner, drive_active,
                  input ready);
  modport sink (input valid, duty_a, duty_b, duty_c, winner, drive_active,
                output ready);
endinterface

/* rtl/olda_front.sv */
module olda_front import olda_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  olda_cmd_if.sink   req,
  output entry_t     push_data,
  output logic       push,
  input  logic       full
);

  front_state_t state, state_next;
  slot_vel_t    slot_vel [SOURCES];
  time_t        slot_dl  [SOURCES];
  time_t        now_reg;
  logic         acc;
  logic [48:0]  dl_sum;
  time_t        dl_sat;
  logic [2:0]   win;

  assign acc    = req.valid && req.ready;
  assign dl_sum = {1'b0, req.now_ms} + 49'(req.lease_ms);
  assign dl_sat = dl_sum[48] ? '1 : dl_sum[47:0];

  // Update slots on a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SOURCES; i++) begin
        slot_vel[i] <= '0;
        slot_dl[i]  <= '0;
      end
    end else if (acc) begin
      if (req.action == ACT_STOP) begin
        for (int i = 0; i < SOURCES; i++) begin
          slot_vel[i] <= '0;
          slot_dl[i]  <= '0;
        end
      end else if (req.action == ACT_REQUEST) begin
        slot_vel[req.source_id] <= '{rot_z: req.rot_z, vel_y: req.vel_y, vel_x: req.vel_x};
        slot_dl[req.source_id]  <= dl_sat;
      end
    end
  end

  // Hold the time of the item
  always_ff @(posedge clk) begin
    if (acc) begin
      now_reg <= req.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Pick the highest priority live lease
  always_comb begin
    win = 3'(SOURCES);
    for (int i = SOURCES - 1; i >= 0; i--) begin
      if (slot_dl[i] > now_reg) begin
        win = 3'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: if (acc) state_next = F_EVAL;
      F_EVAL: if (!full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    req.ready        = 1'b0;
    push             = 1'b0;
    push_data.winner = win;
    push_data.vel    = (win < 3'(SOURCES)) ? slot_vel[win[1:0]] : '0;
    case (state)
      F_IDLE: req.ready = 1'b1;
      F_EVAL: push = !full;
      default: push = 1'b0;
    endcase
  end

endmodule

/* rtl/olda_queue.sv */
`include "omni_drive_lease_arbiter_assert.svh"

module olda_queue import olda_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  input  logic   pop,
  output entry_t pop_data,
  output logic   empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `OLDA_NEVER(a_no_overflow, push && full, "push into full queue")
  `OLDA_NEVER(a_no_underflow, pop && empty, "pop from empty queue")
  `OLDA_NEXT(a_push_fills, push && !pop, !empty, "queue empty after push")

endmodule

/* rtl/olda_back.sv */
module olda_back import olda_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  entry_t         pop_data,
  input  logic           empty,
  output logic           pop,
  input  logic [S_W-1:0] scale,
  input  logic           enable,
  olda_duty_if.source    rsp
);

  back_state_t state, state_next;
  vel_t        vx, vy, wz;
  logic [2:0]  win_r;
  logic signed [33:0]    vxk;
  logic signed [W_W-1:0] w_a, w_b, w_c;
  logic [M_W-1:0]  m [3];
  logic            neg [3];
  logic [M_W-1:0]  peak;
  logic [M_W-1:0]  den;
  logic [DH_W-1:0] dh;
  logic [N_W-1:0]  num;
  logic [N_W-1:0]  dsh;
  logic [Q_W-1:0]  q;
  logic [Q_W-1:0]  q_next;
  logic [Q_W-1:0]  q_clamp;
  logic [3:0]      bidx;
  logic [1:0]      widx;
  duty_t           duty [3];
  logic            fit;

  // Wheel sums
  assign w_a = (W_W'(vy) + W_W'(wz)) <<< 16;
  assign w_b = -W_W'(vxk) - (W_W'(vy) <<< 15) + (W_W'(wz) <<< 16);
  assign w_c =  W_W'(vxk) - (W_W'(vy) <<< 15) + (W_W'(wz) <<< 16);

  // Peak and divisor
  always_comb begin
    peak = m[0];
    if (m[1] > peak) peak = m[1];
    if (m[2] > peak) peak = m[2];
    den = (peak > (M_W'(1) << 30)) ? peak : (M_W'(1) << 30);
  end

  // Divider step
  assign dsh     = N_W'({dh, 1'b0}) << bidx;
  assign fit     = (num >= dsh);
  assign q_next  = {q[Q_W-2:0], fit};
  assign q_clamp = (q_next > Q_W'(DUTY_MAX)) ? Q_W'(DUTY_MAX) : q_next;

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        vx    <= pop_data.vel.vel_x;
        vy    <= pop_data.vel.vel_y;
        wz    <= pop_data.vel.rot_z;
        win_r <= pop_data.winner;
      end
      B_KIN: vxk <= vx * $signed(18'(K_SQRT3_2));
      B_SUM: begin
        neg[0] <= w_a[W_W-1];
        neg[1] <= w_b[W_W-1];
        neg[2] <= w_c[W_W-1];
        m[0]   <= M_W'(w_a[W_W-1] ? -w_a : w_a);
        m[1]   <= M_W'(w_b[W_W-1] ? -w_b : w_b);
        m[2]   <= M_W'(w_c[W_W-1] ? -w_c : w_c);
      end
      B_PEAK: begin
        dh   <= DH_W'(den) * DH_W'(PCT_MAX);
        widx <= '0;
      end
      B_MUL: begin
        num  <= (N_W'(m[widx] * scale) << 1) + N_W'(dh);
        bidx <= 4'(Q_W - 1);
        q    <= '0;
      end
      B_DIV: begin
        if (fit) begin
          num <= num - dsh;
        end
        q    <= q_next;
        bidx <= bidx - 1'b1;
        if (bidx == '0) begin
          duty[widx] <= neg[widx] ? -$signed(q_clamp) : $signed(q_clamp);
          widx       <= widx + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: if (!empty) state_next = B_KIN;
      B_KIN:  state_next = B_SUM;
      B_SUM:  state_next = B_PEAK;
      B_PEAK: state_next = B_MUL;
      B_MUL:  state_next = B_DIV;
      B_DIV: begin
        if (bidx == '0) begin
          state_next = (widx == 2'd2) ? B_OUT : B_MUL;
        end
      end
      B_OUT:  if (rsp.ready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    rsp.valid = 1'b0;
    case (state)
      B_IDLE:  pop = !empty;
      B_OUT:   rsp.valid = 1'b1;
      default: pop = 1'b0;
    endcase
  end

  assign rsp.duty_a       = duty[0];
  assign rsp.duty_b       = duty[1];
  assign rsp.duty_c       = duty[2];
  assign rsp.winner       = win_r;
  assign rsp.drive_active = enable;

endmodule

/* rtl/omni_drive_lease_arbiter.sv */
// Channel | Dir | Carries
// req     | in  | action, source, vel_x, vel_y, rot_z, lease_ms, now_ms
// rsp     | out | duty_a, duty_b, duty_c, winner, drive_active
// apb     | in  | max_duty_percent (0x0), drive_enable (0x4)
//
// The front takes an item, then pushes it into the queue before it takes the next; the back
// runs its setup states (idle, kinematics, sums, peak), then each wheel in turn through the shared
// serial divider (one quotient bit per cycle, 11 bits), then holds its output state.
// Reset (rst, synchronous) clears all leases, percent to 40 and the drive off.
// A stalled rsp holds the back; the queue then fills and req.ready drops.
module omni_drive_lease_arbiter import olda_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  olda_cmd_if.sink    req,
  olda_duty_if.source rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [6:0]     pct;
  logic           en;
  logic           wr;
  logic [S_W-1:0] scale;
  entry_t         push_data, pop_data;
  logic           push, pop, full, empty;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pct <= PCT_RESET;
      en  <= 1'b0;
    end else if (wr) begin
      if (paddr[2] == REG_PERCENT) begin
        pct <= (pwdata[6:0] >= 7'd1 && pwdata[6:0] <= 7'(PCT_MAX)) ? pwdata[6:0]
                                                                   : PCT_RESET;
      end else begin
        en <= pwdata[0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_ENABLE) ? {31'b0, en} : {25'b0, pct};
  assign scale  = S_W'(DUTY_MAX) * {10'b0, pct};

  olda_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .push_data (push_data),
    .push      (push),
    .full      (full)
  );

  olda_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  olda_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_data (pop_data),
    .empty    (empty),
    .pop      (pop),
    .scale    (scale),
    .enable   (en),
    .rsp      (rsp)
  );

endmodule

/* tb/olda_tb_pkg.sv */
`timescale 1ns / 1ps
package olda_tb_pkg;
  import olda_pkg::*;

  // Request field codes and register addresses used by the testbench
  localparam logic [1:0] ACT_TICK   = 2'd1;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [2:0] ADDR_PERCENT = 3'd0;
  localparam logic [2:0] ADDR_ENABLE  = 3'd4;

  typedef struct packed {
    duty_t      duty_a;
    duty_t      duty_b;
    duty_t      duty_c;
    logic [2:0] winner;
    logic       drive_active;
  } wheel_cmd_t;
endpackage

/* tb/olda_checker.sv */
`timescale 1ns / 1ps
module olda_checker import olda_pkg::*; import olda_tb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  olda_cmd_if         req,
  olda_duty_if        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending,
  output int          seen
);
  slot_vel_t  lease_vel[SOURCES];
  time_t      lease_end[SOURCES];
  logic [6:0] scale_pct;
  logic       drive_on;
  wheel_cmd_t duty_queue[$];

  // Scale one wheel value to a duty, rounding half away from zero
  function automatic duty_t wheel_duty(longint signed w, longint unsigned den);
    longint unsigned mag, num, d, q;
    mag = (w < 0) ? longint'(-w) : longint'(w);
    num = mag * DUTY_MAX * scale_pct;
    d = den * 100;
    q = (2 * num + d) / (2 * d);
    if (q > DUTY_MAX) q = DUTY_MAX;
    return (w < 0) ? -duty_t'(q) : duty_t'(q);
  endfunction

  // Apply one action to the leases and work out the wheel command
  function automatic wheel_cmd_t arbitrate_and_mix(logic [1:0] act, logic [1:0] src,
      vel_t vx_in, vel_t vy_in, vel_t wz_in, logic [15:0] ttl, time_t now);
    wheel_cmd_t r;
    longint signed vx, vy, wz, w[3];
    longint unsigned peak, den, m, sum;
    int win;
    win = SOURCES;
    vx = 0; vy = 0; wz = 0; peak = 0;
    if (act == ACT_REQUEST) begin
      sum = longint'(now) + ttl;
      lease_end[src] = (sum > 48'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : time_t'(sum);
      lease_vel[src] = '{rot_z: wz_in, vel_y: vy_in, vel_x: vx_in};
    end else if (act == ACT_STOP) begin
      for (int i = 0; i < SOURCES; i++) begin
        lease_end[i] = '0;
        lease_vel[i] = '0;
      end
    end
    for (int i = SOURCES - 1; i >= 0; i--)
      if (lease_end[i] > now) win = i;
    if (win < SOURCES) begin
      vx = lease_vel[win].vel_x;
      vy = lease_vel[win].vel_y;
      wz = lease_vel[win].rot_z;
    end
    w[0] = vy * 65536 + wz * 65536;
    w[1] = -vx * K_SQRT3_2 - vy * 32768 + wz * 65536;
    w[2] = vx * K_SQRT3_2 - vy * 32768 + wz * 65536;
    for (int i = 0; i < 3; i++) begin
      m = (w[i] < 0) ? longint'(-w[i]) : longint'(w[i]);
      if (m > peak) peak = m;
    end
    den = (peak > (64'd1 << 30)) ? peak : (64'd1 << 30);
    r.duty_a = wheel_duty(w[0], den);
    r.duty_b = wheel_duty(w[1], den);
    r.duty_c = wheel_duty(w[2], den);
    r.winner = win[2:0];
    r.drive_active = drive_on;
    return r;
  endfunction

  assign pending = duty_queue.size();

  always @(posedge clk) begin
    wheel_cmd_t exp_cmd;
    int errs;
    errs = 0;
    if (rst) begin
      for (int i = 0; i < SOURCES; i++) begin
        lease_end[i] = '0;
        lease_vel[i] = '0;
      end
      scale_pct = PCT_RESET;
      drive_on = 1'b0;
      duty_queue.delete();
      fail_count <= 0;
      seen <= 0;
    end else begin
      // Register writes land at the access phase
      if (psel && penable && pwrite) begin
        if (paddr == ADDR_PERCENT)
          scale_pct = (pwdata[6:0] >= 1 && pwdata[6:0] <= PCT_MAX) ? pwdata[6:0] : PCT_RESET;
        else if (paddr == ADDR_ENABLE)
          drive_on = pwdata[0];
      end
      // Predict on each accepted command transfer
      if (req.valid && req.ready)
        duty_queue.push_back(arbitrate_and_mix(req.action, req.source_id, req.vel_x,
                                               req.vel_y, req.rot_z, req.lease_ms,
                                               req.now_ms));
      // Compare each duty transfer against the oldest prediction
      if (rsp.valid && rsp.ready) begin
        seen <= seen + 1;
        if (duty_queue.size() == 0) begin
          $error("unexpected duty transfer");
          errs++;
        end else begin
          exp_cmd = duty_queue.pop_front();
          if (rsp.duty_a !== exp_cmd.duty_a) begin
            $error("duty_a expected %0d got %0d", exp_cmd.duty_a, rsp.duty_a);
            errs++;
          end
          if (rsp.duty_b !== exp_cmd.duty_b) begin
            $error("duty_b expected %0d got %0d", exp_cmd.duty_b, rsp.duty_b);
            errs++;
          end
          if (rsp.duty_c !== exp_cmd.duty_c) begin
            $error("duty_c expected %0d got %0d", exp_cmd.duty_c, rsp.duty_c);
            errs++;
          end
          if (rsp.winner !== exp_cmd.winner) begin
            $error("winner expected %0d got %0d", exp_cmd.winner, rsp.winner);
            errs++;
          end
          if (rsp.drive_active !== exp_cmd.drive_active) begin
            $error("drive_active expected %0d got %0d", exp_cmd.drive_active,
                   rsp.drive_active);
            errs++;
          end
        end
        fail_count <= fail_count + errs;
      end
    end
  end
endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench import olda_pkg::*; import olda_tb_pkg::*;;
  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          fail_count, pending, seen, cycles, sent;
  time_t       clock_ms;
  bit          stall_mode;

  olda_cmd_if  req();
  olda_duty_if rsp();

  omni_drive_lease_arbiter dut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  olda_checker u_checker (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .pending(pending), .seen(seen)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Bound the run
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 800000) begin
        $display("timeout with %0d transfers outstanding", pending);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Receiver stall pattern: long open stretches alternate with heavy stalling
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
      rsp.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Drop valid, drain outstanding duties, then let the back finish before
  // touching registers
  task automatic settle();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Send one command; hold valid until the transfer completes
  task automatic send_cmd(logic [1:0] act, logic [1:0] src, vel_t vx, vel_t vy,
                          vel_t wz, logic [15:0] ttl, time_t now);
    req.valid <= 1'b1;
    req.action <= act; req.source_id <= src; req.vel_x <= vx; req.vel_y <= vy;
    req.rot_z <= wz; req.lease_ms <= ttl; req.now_ms <= now;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sent++;
  endtask

  task automatic idle_gap();
    req.valid <= 1'b0;
    repeat ($urandom_range(1, 40)) @(posedge clk);
  endtask

  task automatic random_cmd();
    int kind;
    logic [1:0] act;
    logic [15:0] ttl;
    kind = $urandom_range(0, 99);
    // Mostly leases and ticks on an advancing clock, some stops and noise
    act = (kind < 55) ? ACT_REQUEST : (kind < 88) ? ACT_TICK :
          (kind < 94) ? ACT_STOP : ACT_UNUSED;
    clock_ms = clock_ms + $urandom_range(0, 30);
    if ($urandom_range(0, 49) == 0) clock_ms = {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
    ttl = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 120));
    send_cmd(act, 2'($urandom), vel_t'($urandom), vel_t'($urandom), vel_t'($urandom),
             ttl, clock_ms);
  endtask

  initial begin
    int burst;
    rst = 1'b1;
    stall_mode = 1'b0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    req.valid = 0; req.action = '0; req.source_id = '0; req.vel_x = '0; req.vel_y = '0;
    req.rot_z = '0; req.lease_ms = '0; req.now_ms = '0;
    sent = 0;
    clock_ms = 48'd1000;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings first, then extremes of fields and actions
    send_cmd(ACT_TICK, 2'd0, 0, 0, 0, 0, 0);
    settle();
    reg_write(ADDR_ENABLE, 32'd1);
    reg_write(ADDR_PERCENT, 32'd100);
    send_cmd(ACT_REQUEST, 2'd3, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 48'd5);
    send_cmd(ACT_REQUEST, 2'd2, -16'sd32768, -16'sd32768, -16'sd32768, 16'd10, 48'd5);
    send_cmd(ACT_REQUEST, 2'd1, 16'sd16384, 16'sd0, 16'sd0, 16'd1, 48'd6);
    send_cmd(ACT_REQUEST, 2'd0, 16'sd0, 16'sd8192, -16'sd4096, 16'd0, 48'd6);
    send_cmd(ACT_TICK, 2'd0, 0, 0, 0, 0, 48'd6);
    send_cmd(ACT_UNUSED, 2'd1, 16'sh1234, 0, 0, 16'd99, 48'd14);
    send_cmd(ACT_TICK, 2'd0, 0, 0, 0, 0, 48'd15);
    send_cmd(ACT_REQUEST, 2'd0, 16'sd1, -16'sd1, 16'sd1, 16'hFFFF, 48'hFFFF_FFFF_FFF0);
    send_cmd(ACT_TICK, 2'd0, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFE);
    send_cmd(ACT_STOP, 2'd0, 0, 0, 0, 0, 48'd20);
    send_cmd(ACT_REQUEST, 2'd1, 16'sd100, 16'sd200, 16'sd300, 16'd50, 48'd20);
    settle();
    reg_write(ADDR_PERCENT, 32'd1);
    reg_write(ADDR_ENABLE, 32'd0);
    send_cmd(ACT_REQUEST, 2'd0, 16'sd16384, 16'sd16384, 16'sd16384, 16'd50, 48'd21);
    settle();
    reg_write(ADDR_PERCENT, 32'd0);
    send_cmd(ACT_TICK, 2'd0, 0, 0, 0, 0, 48'd22);
    settle();
    reg_write(ADDR_PERCENT, 32'd127);
    reg_write(ADDR_PERCENT, 32'hFFFF_FF65);
    send_cmd(ACT_TICK, 2'd0, 0, 0, 0, 0, 48'd23);
    req.valid <= 1'b0;

    // Random phases, each under its own register setting
    for (int phase = 0; phase < 8; phase++) begin
      settle();
      reg_write(ADDR_PERCENT, (phase == 0) ? 32'd100 : (phase == 1) ? 32'd1 :
                              (phase == 2) ? 32'd101 : $urandom);
      reg_write(ADDR_ENABLE, $urandom);
      while (sent < 25 + 250 * (phase + 1)) begin
        burst = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 12);
        for (int i = 0; i < burst; i++) random_cmd();
        idle_gap();
      end
    end
    req.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("sent %0d commands across 9 register settings, checked %0d duty transfers",
             sent, seen);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
